[hw/rtl/due_slot_scheduler_with_affinity_top_macros.svh]
// Assertion macros for the due-slot scheduler checker.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef DUE_SLOT_SCHEDULER_WITH_AFFINITY_TOP_MACROS_SVH
`define DUE_SLOT_SCHEDULER_WITH_AFFINITY_TOP_MACROS_SVH

// same-cycle implication
`define DSS_ASSERT_NOW(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error("dss assertion failed");

// next-cycle implication
`define DSS_ASSERT_NEXT(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error("dss assertion failed");

`endif

[hw/rtl/dss_pkg.sv]
// Shared codes for the due-slot scheduler: action and register index codes.
// No dependencies.
`default_nettype none

package dss_pkg;

    typedef logic [2:0] action_t;

    localparam action_t ACT_PICK     = 3'd0;
    localparam action_t ACT_COMPLETE = 3'd1;
    localparam action_t ACT_MARK_DUE = 3'd2;
    localparam action_t ACT_RESIZE   = 3'd3;
    localparam action_t ACT_WRITE    = 3'd4;

    typedef logic [0:0] cfg_index_t;

    localparam cfg_index_t CFG_RETRY_INTERVAL = 1'd0;
    localparam cfg_index_t CFG_FIXED_SLOTS    = 1'd1;

    localparam int unsigned TIME_W     = 32;
    localparam int unsigned INTERVAL_W = 16;
    localparam int unsigned TAG_W      = 4;

endpackage

`default_nettype wire

[hw/rtl/due_slot_scheduler_with_affinity_top.sv]
// Due-slot scheduler with host affinity, top level.
// Depends on dss_pkg.
//
// Input channel in_valid/in_ready carries one command word (action, now,
// open_host, slot, success, slot_count, interval, host_tag). Output channel
// out_valid/out_ready returns exactly one result word (found, picked_slot)
// per command. cfg_we/cfg_index/cfg_data write retry_interval (index 0) and
// fixed_slots (index 1). A pick reads the due-time memory one slot per cycle
// over the active slots; mark-all-due writes the due time of each active
// slot in turn and resize those from fixed_slots up to the new count;
// completion reads the interval, then writes the due time; slot write and
// unknown actions go straight to the result stage. One command is in flight
// at a time; the next is taken the cycle after the result is loaded.
// Reset: all due times read as zero (per-slot valid bits), three active
// slots, retry_interval 60, fixed_slots 3. Interval and host tag stores are
// undefined until written. A stalled receiver holds the result word; a
// following command still runs but waits to load its result until the
// output register is free.
`default_nettype none

module due_slot_scheduler_with_affinity_top #(
    parameter int MAX_SLOTS = 32,
    parameter int HOST_TAGS = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire dss_pkg::action_t                     action,
    input  wire logic [dss_pkg::TIME_W-1:0]           now,
    input  wire logic [dss_pkg::TAG_W-1:0]            open_host,
    input  wire logic [4:0]                           slot,
    input  wire logic                                 success,
    input  wire logic [5:0]                           slot_count,
    input  wire logic [dss_pkg::INTERVAL_W-1:0]       interval,
    input  wire logic [dss_pkg::TAG_W-1:0]            host_tag,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic                                      found,
    output logic [4:0]                                picked_slot,
    input  wire logic                                 cfg_we,
    input  wire dss_pkg::cfg_index_t                  cfg_index,
    input  wire logic [15:0]                          cfg_data
);
    import dss_pkg::*;

    localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int IW = INTERVAL_W + TAG_W;
    localparam logic [CW-1:0] ACTIVE_RST = CW'((MAX_SLOTS < 3) ? MAX_SLOTS : 3);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_CPL_RD = 3'd2;
    localparam logic [2:0] S_CPL_WR = 3'd3;
    localparam logic [2:0] S_SWEEP  = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    // memories
    logic [TIME_W-1:0] due_mem  [MAX_SLOTS];
    logic [IW-1:0]     info_mem [MAX_SLOTS];
    logic [TIME_W-1:0] due_rd_reg;
    logic [IW-1:0]     info_rd_reg;
    logic              due_vld_rd_reg;

    logic              due_vld_reg [MAX_SLOTS];

    // control
    logic [2:0]        state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     end_reg, end_next;
    logic [CW-1:0]     active_reg, active_next;
    logic              pend_reg, pend_next;
    logic              aff_found_reg, aff_found_next;
    logic              old_found_reg, old_found_next;
    logic              out_valid_reg, out_valid_next;
    logic [15:0]       retry_reg;
    logic [5:0]        fixed_reg;

    // payload
    logic [SW-1:0]     pend_idx_reg, pend_idx_next;
    logic [SW-1:0]     aff_idx_reg, aff_idx_next;
    logic [SW-1:0]     old_idx_reg, old_idx_next;
    logic [TIME_W-1:0] oldest_reg, oldest_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [TAG_W-1:0]  open_host_reg, open_host_next;
    logic              aff_en_reg, aff_en_next;
    logic              success_reg, success_next;
    logic [SW-1:0]     slot_idx_reg, slot_idx_next;
    logic              slot_ok_reg, slot_ok_next;
    logic              found_reg, found_next;
    logic [4:0]        picked_reg, picked_next;

    // memory ports
    logic [SW-1:0]     rd_addr;
    logic              due_we;
    logic [SW-1:0]     due_waddr;
    logic [TIME_W-1:0] due_wdata;
    logic              info_we;
    logic [IW-1:0]     info_wdata;

    logic              accept;
    logic [TIME_W-1:0] due_cur;
    logic              is_due;
    logic              aff_hit;
    logic              old_hit;
    logic [CW-1:0]     new_count;
    logic [TAG_W-1:0]  tag_store;
    logic              slot_in_range;

    assign accept        = in_valid && in_ready;
    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign picked_slot   = picked_reg;

    assign due_cur       = due_vld_rd_reg ? due_rd_reg : '0;
    assign is_due        = (due_cur <= now_reg);
    assign aff_hit       = aff_en_reg && !aff_found_reg && is_due
                           && (info_rd_reg[TAG_W-1:0] == open_host_reg);
    assign old_hit       = is_due && (!old_found_reg || (due_cur < oldest_reg));
    assign new_count     = (32'(slot_count) > MAX_SLOTS) ? CW'(MAX_SLOTS) : CW'(slot_count);
    assign tag_store     = (32'(host_tag) < HOST_TAGS) ? host_tag : '0;
    assign slot_in_range = (32'(slot) < MAX_SLOTS);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        end_next       = end_reg;
        active_next    = active_reg;
        pend_next      = pend_reg;
        aff_found_next = aff_found_reg;
        old_found_next = old_found_reg;
        out_valid_next = out_valid_reg;
        pend_idx_next  = pend_idx_reg;
        aff_idx_next   = aff_idx_reg;
        old_idx_next   = old_idx_reg;
        oldest_next    = oldest_reg;
        now_next       = now_reg;
        open_host_next = open_host_reg;
        aff_en_next    = aff_en_reg;
        success_next   = success_reg;
        slot_idx_next  = slot_idx_reg;
        slot_ok_next   = slot_ok_reg;
        found_next     = found_reg;
        picked_next    = picked_reg;
        rd_addr        = '0;
        due_we         = 1'b0;
        due_waddr      = cnt_reg[SW-1:0];
        due_wdata      = now_reg;
        info_we        = 1'b0;
        info_wdata     = {interval, tag_store};

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    now_next       = now;
                    open_host_next = open_host;
                    aff_en_next    = (open_host != '0) && (32'(open_host) < HOST_TAGS);
                    success_next   = success;
                    slot_idx_next  = SW'(slot);
                    slot_ok_next   = slot_in_range;
                    aff_found_next = 1'b0;
                    old_found_next = 1'b0;
                    pend_next      = 1'b0;
                    cnt_next       = '0;
                    unique case (action)
                        ACT_PICK:
                        begin
                            end_next   = active_reg;
                            state_next = S_SCAN;
                        end
                        ACT_COMPLETE:
                        begin
                            state_next = S_CPL_RD;
                        end
                        ACT_MARK_DUE:
                        begin
                            end_next   = active_reg;
                            state_next = S_SWEEP;
                        end
                        ACT_RESIZE:
                        begin
                            active_next = new_count;
                            end_next    = new_count;
                            cnt_next    = (32'(fixed_reg) >= 32'(new_count))
                                          ? new_count : CW'(fixed_reg);
                            state_next  = S_SWEEP;
                        end
                        ACT_WRITE:
                        begin
                            info_we    = slot_in_range;
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (pend_reg)
                begin
                    if (aff_hit)
                    begin
                        aff_found_next = 1'b1;
                        aff_idx_next   = pend_idx_reg;
                    end
                    if (old_hit)
                    begin
                        old_found_next = 1'b1;
                        old_idx_next   = pend_idx_reg;
                        oldest_next    = due_cur;
                    end
                end
                if (cnt_reg < end_reg)
                begin
                    rd_addr       = cnt_reg[SW-1:0];
                    pend_next     = 1'b1;
                    pend_idx_next = cnt_reg[SW-1:0];
                    cnt_next      = cnt_reg + 1'b1;
                end
                else
                begin
                    // last slot is compared this cycle
                    pend_next  = 1'b0;
                    state_next = S_DONE;
                end
            end
            S_CPL_RD:
            begin
                rd_addr    = slot_idx_reg;
                state_next = S_CPL_WR;
            end
            S_CPL_WR:
            begin
                due_we     = slot_ok_reg;
                due_waddr  = slot_idx_reg;
                due_wdata  = now_reg + (success_reg
                             ? TIME_W'(info_rd_reg[IW-1:TAG_W]) : TIME_W'(retry_reg));
                state_next = S_DONE;
            end
            S_SWEEP:
            begin
                if (cnt_reg < end_reg)
                begin
                    due_we   = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    found_next     = aff_found_reg || old_found_reg;
                    priority if (aff_found_reg)
                    begin
                        picked_next = 5'(aff_idx_reg);
                    end
                    else if (old_found_reg)
                    begin
                        picked_next = 5'(old_idx_reg);
                    end
                    else
                    begin
                        picked_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            end_reg       <= '0;
            active_reg    <= ACTIVE_RST;
            pend_reg      <= 1'b0;
            aff_found_reg <= 1'b0;
            old_found_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            retry_reg     <= 16'd60;
            fixed_reg     <= 6'd3;
            for (int i = 0; i < MAX_SLOTS; i++)
            begin
                due_vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            end_reg       <= end_next;
            active_reg    <= active_next;
            pend_reg      <= pend_next;
            aff_found_reg <= aff_found_next;
            old_found_reg <= old_found_next;
            out_valid_reg <= out_valid_next;
            if (due_we)
            begin
                due_vld_reg[due_waddr] <= 1'b1;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_RETRY_INTERVAL: retry_reg <= cfg_data;
                    CFG_FIXED_SLOTS:    fixed_reg <= cfg_data[5:0];
                    default:            retry_reg <= retry_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg  <= pend_idx_next;
        aff_idx_reg   <= aff_idx_next;
        old_idx_reg   <= old_idx_next;
        oldest_reg    <= oldest_next;
        now_reg       <= now_next;
        open_host_reg <= open_host_next;
        aff_en_reg    <= aff_en_next;
        success_reg   <= success_next;
        slot_idx_reg  <= slot_idx_next;
        slot_ok_reg   <= slot_ok_next;
        found_reg     <= found_next;
        picked_reg    <= picked_next;
    end

    // due-time store
    always_ff @(posedge clk)
    begin
        if (due_we)
        begin
            due_mem[due_waddr] <= due_wdata;
        end
        due_rd_reg     <= due_mem[rd_addr];
        due_vld_rd_reg <= due_vld_reg[rd_addr];
    end

    // interval and host tag store
    always_ff @(posedge clk)
    begin
        if (info_we)
        begin
            info_mem[SW'(slot)] <= info_wdata;
        end
        info_rd_reg <= info_mem[rd_addr];
    end

endmodule

`default_nettype wire

[hw/rtl/dss_checker.sv]
// Port-level checker for the due-slot scheduler, bound to the top level.
// Depends on due_slot_scheduler_with_affinity_top_macros.svh.
`default_nettype none

`include "due_slot_scheduler_with_affinity_top_macros.svh"

module dss_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       found,
    input wire logic [4:0] picked_slot
);

    // stalled result word holds
    `DSS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(found) && $stable(picked_slot))

    // no slot reported without a hit
    `DSS_ASSERT_NOW(a_none_zero, out_valid && !found, picked_slot == 5'd0)

    // one command in flight: busy right after an acceptance
    `DSS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

endmodule

bind due_slot_scheduler_with_affinity_top dss_checker u_dss_checker (.*);

`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for the due-slot scheduler: directed and random command words,
// an in-bench scheduler that predicts every reply word, random gaps on both channels.
// Depends on dss_pkg and due_slot_scheduler_with_affinity_top.

module tb_top;
    import dss_pkg::*;

    localparam int SLOTS            = 32;
    localparam int PHASES           = 8;
    localparam int RANDOM_PER_PHASE = 215;
    localparam int MAX_PRINTED      = 40;
    localparam int SETTLE_CYCLES    = 40;

    localparam action_t ACT_SPARE_A = 3'd5;
    localparam action_t ACT_SPARE_B = 3'd6;
    localparam action_t ACT_SPARE_C = 3'd7;

    localparam int unsigned RETRY_SET [PHASES] = '{60, 1, 65535, 4711, 600, 1, 65535, 300};
    localparam int unsigned FIXED_SET [PHASES] = '{3, 0, 32, 63, 1, 5, 16, 0};
    localparam int unsigned TX_IDLE [PHASES]   = '{0, 88, 0, 13, 0, 88, 0, 13};
    localparam int unsigned RX_STALL [PHASES]  = '{0, 0, 88, 13, 0, 0, 88, 13};

    typedef struct {
        action_t     action;
        logic [31:0] now;
        logic [3:0]  open_host;
        logic [4:0]  slot;
        logic        success;
        logic [5:0]  slot_count;
        logic [15:0] interval;
        logic [3:0]  host_tag;
    } sched_cmd_t;

    typedef struct {
        action_t    action;
        logic       found;
        logic [4:0] picked_slot;
    } sched_reply_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    action_t     action      = ACT_PICK;
    logic [31:0] now         = '0;
    logic [3:0]  open_host   = '0;
    logic [4:0]  slot        = '0;
    logic        success     = 1'b0;
    logic [5:0]  slot_count  = '0;
    logic [15:0] interval    = '0;
    logic [3:0]  host_tag    = '0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic        found;
    logic [4:0]  picked_slot;
    logic        cfg_we      = 1'b0;
    cfg_index_t  cfg_index   = CFG_RETRY_INTERVAL;
    logic [15:0] cfg_data    = '0;

    // scheduler state as the bench sees it
    logic [31:0] sd_due [SLOTS] = '{default: '0};
    logic [15:0] sd_ivl [SLOTS] = '{default: '0};
    logic [3:0]  sd_tag [SLOTS] = '{default: '0};
    int unsigned sd_active = 3;
    logic [15:0] cfg_retry = 16'd60;
    logic [5:0]  cfg_fixed = 6'd3;

    // stimulus-side shadow, kept at generation time
    logic [31:0]      gen_clock   = 32'd1000;
    int unsigned      gen_active  = 3;
    logic [SLOTS-1:0] gen_written = '0;

    sched_cmd_t   cmd_q [$];
    sched_reply_t sched_reply_q [$];

    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;
    int unsigned n_sent       = 0;
    int unsigned n_accepted   = 0;
    int unsigned n_results    = 0;
    int unsigned n_errors     = 0;
    int unsigned n_picks      = 0;
    int unsigned n_found      = 0;
    int unsigned n_affinity   = 0;
    int unsigned n_settings   = 0;

    due_slot_scheduler_with_affinity_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .now         (now),
        .open_host   (open_host),
        .slot        (slot),
        .success     (success),
        .slot_count  (slot_count),
        .interval    (interval),
        .host_tag    (host_tag),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .found       (found),
        .picked_slot (picked_slot),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    task automatic report_mismatch(input string msg);
        if (n_errors < MAX_PRINTED)
            $display("mismatch @%0t: %s", $time, msg);
        n_errors++;
    endtask

    task automatic schedule_step(input sched_cmd_t c, output sched_reply_t r);
        logic [32:0] oldest;
        int unsigned n;
        r.action      = c.action;
        r.found       = 1'b0;
        r.picked_slot = '0;
        case (c.action)
            ACT_PICK:
            begin
                n_picks++;
                if (c.open_host != '0)
                    for (int i = 0; i < sd_active; i++)
                        if (!r.found && sd_due[i] <= c.now && sd_tag[i] == c.open_host)
                        begin
                            r.found       = 1'b1;
                            r.picked_slot = 5'(i);
                        end
                if (r.found)
                    n_affinity++;
                else
                begin
                    oldest = {1'b0, c.now} + 33'd1;
                    for (int i = 0; i < sd_active; i++)
                        if (sd_due[i] <= c.now && {1'b0, sd_due[i]} < oldest)
                        begin
                            oldest        = {1'b0, sd_due[i]};
                            r.found       = 1'b1;
                            r.picked_slot = 5'(i);
                        end
                end
                if (r.found)
                    n_found++;
            end
            ACT_COMPLETE:
                sd_due[c.slot] = c.now + (c.success ? {16'd0, sd_ivl[c.slot]} : {16'd0, cfg_retry});
            ACT_MARK_DUE:
                for (int i = 0; i < sd_active; i++)
                    sd_due[i] = c.now;
            ACT_RESIZE:
            begin
                n = (c.slot_count > SLOTS) ? SLOTS : c.slot_count;
                sd_active = n;
                for (int i = cfg_fixed; i < n; i++)
                    sd_due[i] = c.now;
            end
            ACT_WRITE:
            begin
                sd_ivl[c.slot] = c.interval;
                sd_tag[c.slot] = c.host_tag;
            end
            default:
                r.found = 1'b0;
        endcase
    endtask

    // never lets a word read an interval or host tag that was not written
    task automatic queue_cmd(input sched_cmd_t c);
        logic all_written;
        all_written = 1'b1;
        for (int i = 0; i < gen_active; i++)
            if (!gen_written[i])
                all_written = 1'b0;
        if (c.action == ACT_PICK && !all_written)
            c.open_host = '0;
        if (c.action == ACT_COMPLETE && !gen_written[c.slot])
            c.success = 1'b0;
        if (c.action == ACT_WRITE)
            gen_written[c.slot] = 1'b1;
        if (c.action == ACT_RESIZE)
            gen_active = (c.slot_count > SLOTS) ? SLOTS : c.slot_count;
        cmd_q.push_back(c);
    endtask

    function automatic sched_cmd_t mk_cmd(input action_t a, input logic [31:0] t,
                                          input logic [3:0] oh, input logic [4:0] s,
                                          input logic ok, input logic [5:0] cnt,
                                          input logic [15:0] ivl, input logic [3:0] tag);
        sched_cmd_t c;
        c.action     = a;
        c.now        = t;
        c.open_host  = oh;
        c.slot       = s;
        c.success    = ok;
        c.slot_count = cnt;
        c.interval   = ivl;
        c.host_tag   = tag;
        return c;
    endfunction

    function automatic sched_cmd_t rand_cmd();
        sched_cmd_t  c;
        int unsigned r;
        int unsigned s;
        r            = $urandom_range(99);
        c.action     = ACT_PICK;
        c.open_host  = 4'($urandom);
        c.slot       = 5'($urandom);
        c.success    = 1'($urandom);
        c.slot_count = 6'($urandom);
        c.interval   = 16'($urandom);
        c.host_tag   = 4'($urandom);
        gen_clock = gen_clock + $urandom_range(30);
        if ($urandom_range(24) == 0)
            gen_clock = $urandom;
        c.now = ($urandom_range(39) == 0) ? 32'($urandom) : gen_clock;
        if (r < 40)
        begin
            c.action = ACT_PICK;
            if ($urandom_range(3) != 0)
                c.open_host = 4'($urandom_range(4));
        end
        else if (r < 65)
        begin
            c.action = ACT_COMPLETE;
            if (gen_active != 0 && $urandom_range(3) != 0)
                c.slot = 5'($urandom_range(gen_active - 1));
        end
        else if (r < 80)
        begin
            c.action = ACT_WRITE;
            s = $urandom_range(SLOTS - 1);
            if (gen_written != '1 && $urandom_range(1) == 0)
                while (gen_written[s])
                    s = (s + 1) % SLOTS;
            c.slot = 5'(s);
            if ($urandom_range(4) != 0)
            begin
                c.interval = 16'($urandom_range(300, 1));
                c.host_tag = 4'($urandom_range(4));
            end
        end
        else if (r < 88)
        begin
            c.action = ACT_RESIZE;
            if ($urandom_range(9) < 7)
                c.slot_count = 6'($urandom_range(8));
        end
        else if (r < 95)
            c.action = ACT_MARK_DUE;
        else
            case ($urandom_range(2))
                0:       c.action = ACT_SPARE_A;
                1:       c.action = ACT_SPARE_B;
                default: c.action = ACT_SPARE_C;
            endcase
        return c;
    endfunction

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_RETRY_INTERVAL)
            cfg_retry = val;
        else
            cfg_fixed = val[5:0];
        n_settings++;
    endtask

    always @(negedge clk)
    begin : driver
        sched_cmd_t c;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= rx_stall_pct);
            if (n_sent == n_accepted)
            begin
                if (cmd_q.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    c = cmd_q.pop_front();
                    action     <= c.action;
                    now        <= c.now;
                    open_host  <= c.open_host;
                    slot       <= c.slot;
                    success    <= c.success;
                    slot_count <= c.slot_count;
                    interval   <= c.interval;
                    host_tag   <= c.host_tag;
                    in_valid   <= 1'b1;
                    n_sent     <= n_sent + 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        sched_cmd_t   c;
        sched_reply_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                n_results++;
                if (sched_reply_q.size() == 0)
                    report_mismatch($sformatf("reply %0d arrived with none outstanding",
                                              n_results));
                else
                begin
                    want = sched_reply_q.pop_front();
                    if (found !== want.found)
                        report_mismatch($sformatf("reply %0d (action %0d): found %b, want %b",
                                                  n_results, want.action, found, want.found));
                    if (picked_slot !== want.picked_slot)
                        report_mismatch($sformatf("reply %0d (action %0d): slot %0d, want %0d",
                                                  n_results, want.action, picked_slot,
                                                  want.picked_slot));
                end
            end
            if (in_valid && in_ready)
            begin
                c.action     = action;
                c.now        = now;
                c.open_host  = open_host;
                c.slot       = slot;
                c.success    = success;
                c.slot_count = slot_count;
                c.interval   = interval;
                c.host_tag   = host_tag;
                schedule_step(c, want);
                sched_reply_q.push_back(want);
                n_accepted <= n_accepted + 1;
            end
        end
    end

    initial
    begin : stimulus
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        for (int p = 0; p < PHASES; p++)
        begin
            write_reg(CFG_RETRY_INTERVAL, 16'(RETRY_SET[p]));
            write_reg(CFG_FIXED_SLOTS, 16'(FIXED_SET[p]));
            tx_idle_pct  = TX_IDLE[p];
            rx_stall_pct = RX_STALL[p];
            if (p == 0)
            begin
                // all slots due at zero after reset
                queue_cmd(mk_cmd(ACT_PICK, 32'd0, 4'd0, 5'd0, 1'b0, 6'd0, 16'd0, 4'd0));
                queue_cmd(mk_cmd(ACT_WRITE, 32'd0, 4'd0, 5'd0, 1'b0, 6'd0, 16'hFFFF, 4'd15));
                queue_cmd(mk_cmd(ACT_WRITE, 32'd0, 4'd0, 5'd1, 1'b0, 6'd0, 16'd1, 4'd1));
                queue_cmd(mk_cmd(ACT_WRITE, 32'd0, 4'd0, 5'd2, 1'b0, 6'd0, 16'd0, 4'd0));
                queue_cmd(mk_cmd(ACT_WRITE, 32'd0, 4'd0, 5'd31, 1'b0, 6'd0, 16'h8000, 4'd8));
                queue_cmd(mk_cmd(ACT_PICK, 32'd0, 4'd15, 5'd0, 1'b0, 6'd0, 16'd0, 4'd0));
                // due time wraps past the top
                queue_cmd(mk_cmd(ACT_COMPLETE, 32'hFFFF_FFFF, 4'd0, 5'd0, 1'b1, 6'd0, 16'd0,
                                 4'd0));
                queue_cmd(mk_cmd(ACT_PICK, 32'd100, 4'd15, 5'd0, 1'b0, 6'd0, 16'd0, 4'd0));
                queue_cmd(mk_cmd(ACT_COMPLETE, 32'd1000, 4'd0, 5'd1, 1'b0, 6'd0, 16'd0, 4'd0));
                queue_cmd(mk_cmd(ACT_COMPLETE, 32'd2000, 4'd0, 5'd2, 1'b1, 6'd0, 16'd0, 4'd0));
                queue_cmd(mk_cmd(ACT_PICK, 32'd1500, 4'd1, 5'd0, 1'b0, 6'd0, 16'd0, 4'd0));
                queue_cmd(mk_cmd(ACT_PICK, 32'hFFFF_FFFF, 4'd2, 5'd0, 1'b0, 6'd0, 16'd0, 4'd0));
                queue_cmd(mk_cmd(ACT_MARK_DUE, 32'd5, 4'd0, 5'd0, 1'b0, 6'd0, 16'd0, 4'd0));
                queue_cmd(mk_cmd(ACT_PICK, 32'd4, 4'd0, 5'd0, 1'b0, 6'd0, 16'd0, 4'd0));
                queue_cmd(mk_cmd(ACT_PICK, 32'd5, 4'd1, 5'd0, 1'b0, 6'd0, 16'd0, 4'd0));
                // oversized resize saturates
                queue_cmd(mk_cmd(ACT_RESIZE, 32'd7, 4'd0, 5'd0, 1'b0, 6'd63, 16'd0, 4'd0));
                queue_cmd(mk_cmd(ACT_PICK, 32'd6, 4'd0, 5'd0, 1'b0, 6'd0, 16'd0, 4'd0));
                queue_cmd(mk_cmd(ACT_RESIZE, 32'd9, 4'd0, 5'd0, 1'b0, 6'd0, 16'd0, 4'd0));
                queue_cmd(mk_cmd(ACT_PICK, 32'hFFFF_FFFF, 4'd15, 5'd0, 1'b0, 6'd0, 16'd0,
                                 4'd0));
                queue_cmd(mk_cmd(ACT_RESIZE, 32'd11, 4'd0, 5'd0, 1'b0, 6'd3, 16'd0, 4'd0));
                queue_cmd(mk_cmd(ACT_COMPLETE, 32'hFFFF_FFF0, 4'd0, 5'd31, 1'b1, 6'd0, 16'd0,
                                 4'd0));
                queue_cmd(mk_cmd(ACT_SPARE_A, 32'hFFFF_FFFF, 4'hF, 5'h1F, 1'b1, 6'h3F,
                                 16'hFFFF, 4'hF));
                queue_cmd(mk_cmd(ACT_SPARE_B, 32'hFFFF_FFFF, 4'hF, 5'h1F, 1'b1, 6'h3F,
                                 16'hFFFF, 4'hF));
                queue_cmd(mk_cmd(ACT_SPARE_C, 32'hFFFF_FFFF, 4'hF, 5'h1F, 1'b1, 6'h3F,
                                 16'hFFFF, 4'hF));
                queue_cmd(mk_cmd(ACT_PICK, 32'hFFFF_FFFF, 4'd8, 5'd0, 1'b0, 6'd0, 16'd0, 4'd0));
            end
            for (int k = 0; k < RANDOM_PER_PHASE; k++)
                queue_cmd(rand_cmd());
            // the next phase waits until every reply is back
            do
                @(posedge clk);
            while (cmd_q.size() != 0 || n_sent != n_accepted || sched_reply_q.size() != 0);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("ran %0d command words and %0d replies over %0d register settings",
                 n_accepted, n_results, n_settings);
        $display("%0d picks: %0d found a due slot, %0d of them by host match",
                 n_picks, n_found, n_affinity);
        if (n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : watchdog
        #40_000_000;
        $display("timeout: %0d words sent, %0d replies", n_accepted, n_results);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
